// ----- hdl/fsed_pkg.sv -----
`timescale 1ns / 1ps

package fsed_pkg;

  // Line geometry.
  localparam int unsigned MaxCols  = 2048;
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned RowLimit = 4096;
  localparam int unsigned RowW     = $clog2(RowLimit);

  // Configuration port.
  localparam int unsigned ColsRegW = 12;
  localparam int unsigned RowsRegW = 13;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgIdxImageCols = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxImageRows = 1'b1;

  // Pixel and error arithmetic.
  localparam int unsigned ChanW       = 8;
  localparam int unsigned LevelBits   = 4;
  localparam int unsigned TopLevel    = 240;
  localparam int unsigned ErrFracBits = 8;
  localparam int unsigned QuantShift  = ErrFracBits + LevelBits;
  localparam int unsigned PxW         = ChanW + ErrFracBits;
  localparam int unsigned ErrW        = ErrFracBits + 5;
  localparam int unsigned SumW        = PxW + 2;
  localparam int unsigned MulW        = ErrW + 3;

  localparam logic [PxW-1:0] TopFx  = PxW'(TopLevel * (2 ** ErrFracBits));
  localparam logic [PxW-1:0] HalfFx = PxW'(2 ** (QuantShift - 1));

  typedef logic signed [ErrW-1:0] err_t;

  // One line store entry holds the error of all three channels.
  typedef struct packed {
    err_t blue;
    err_t green;
    err_t red;
  } line_word_t;

  typedef struct packed {
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] red_in;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] blue_level;
    logic [ChanW-1:0] green_level;
    logic [ChanW-1:0] red_level;
    logic             frame_end;
  } result_t;

  // Position of the pixel held in the working register.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            last_col;
    logic            last_row;
    logic            row_nz;
  } pos_t;

  // Handshake events shared by the datapath parts.
  typedef struct packed {
    logic accept;
    logic fire;
  } ctrl_t;

endpackage

// ----- hdl/fsed_ctrl.sv -----
`timescale 1ns / 1ps

module fsed_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fsed_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fsed_pkg::CfgDataW-1:0]   cfg_data_i,
  output fsed_pkg::ctrl_t                 ctrl_o,
  output fsed_pkg::pos_t                  pos_o,
  output logic [fsed_pkg::ColW-1:0]       rd_addr_o
);

  logic [fsed_pkg::ColsRegW-1:0] cols_q, cols_d;
  logic [fsed_pkg::RowsRegW-1:0] rows_q, rows_d;
  logic [fsed_pkg::ColW-1:0]     col_q, col_d;
  logic [fsed_pkg::RowW-1:0]     row_q, row_d;
  logic                          s1_valid_q, s1_valid_d;
  logic                          out_valid_q, out_valid_d;
  fsed_pkg::pos_t                pos_q, pos_d;

  logic [fsed_pkg::ColW:0]       cols_eff;
  logic [fsed_pkg::RowW:0]       rows_eff;
  logic [fsed_pkg::ColW:0]       col_inc;
  logic [fsed_pkg::RowW:0]       row_inc;
  logic                          last_col;
  logic                          last_row;
  logic                          accept;
  logic                          fire;

  // Always taken; user must write only while the block is idle, unenforced.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fsed_pkg::CfgIdxImageCols: cols_d = cfg_data_i[fsed_pkg::ColsRegW-1:0];
        fsed_pkg::CfgIdxImageRows: rows_d = cfg_data_i[fsed_pkg::RowsRegW-1:0];
        default: begin
          cols_d = cols_q;
          rows_d = rows_q;
        end
      endcase
    end
  end

  // Clamp the frame size to the supported range.
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = (fsed_pkg::ColW+1)'(1);
    end else if (32'(cols_q) > fsed_pkg::MaxCols) begin
      cols_eff = (fsed_pkg::ColW+1)'(fsed_pkg::MaxCols);
    end else begin
      cols_eff = (fsed_pkg::ColW+1)'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = (fsed_pkg::RowW+1)'(1);
    end else if (32'(rows_q) > fsed_pkg::RowLimit) begin
      rows_eff = (fsed_pkg::RowW+1)'(fsed_pkg::RowLimit);
    end else begin
      rows_eff = (fsed_pkg::RowW+1)'(rows_q);
    end
  end

  // Edge flags for the pixel at the current raster position.
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign last_col = (col_inc >= cols_eff);
  assign last_row = (row_inc >= rows_eff);

  // Working register moves on when the result register is free or drains.
  assign fire       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Raster counters advance as each word is accepted.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    if (accept) begin
      pos_d.col      = col_q;
      pos_d.last_col = last_col;
      pos_d.last_row = last_row;
      pos_d.row_nz   = (row_q != '0);
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[fsed_pkg::RowW-1:0];
      end else begin
        col_d = col_inc[fsed_pkg::ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= fsed_pkg::ColsRegW'(fsed_pkg::MaxCols);
      rows_q      <= fsed_pkg::RowsRegW'(fsed_pkg::RowLimit);
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ctrl_o.accept = accept;
  assign ctrl_o.fire   = fire;
  assign pos_o         = pos_q;
  assign rd_addr_o     = col_q;

endmodule

// ----- hdl/fsed_line_store.sv -----
`timescale 1ns / 1ps

module fsed_line_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fsed_pkg::ctrl_t             ctrl_i,
  input  logic [fsed_pkg::ColW-1:0]   rd_addr_i,
  input  logic [fsed_pkg::ColW-1:0]   s1_addr_i,
  input  logic                        w1_en_i,
  input  fsed_pkg::line_word_t        w1_data_i,
  input  logic                        w2_en_i,
  input  fsed_pkg::line_word_t        w2_data_i,
  output fsed_pkg::line_word_t        rd_data_o
);

  fsed_pkg::line_word_t          mem [fsed_pkg::MaxCols];
  fsed_pkg::line_word_t          mem_rd_q;

  // The entry at the current column is held back one pixel: the next pixel
  // of the row overwrites it, so it reaches the memory only when it is final.
  logic                          tail_valid_q, tail_valid_d;
  logic [fsed_pkg::ColW-1:0]     tail_addr_q, tail_addr_d;
  fsed_pkg::line_word_t          tail_data_q, tail_data_d;

  // Copy of the latest memory write, for a read taken at the same edge.
  logic                          lw_valid_q;
  logic [fsed_pkg::ColW-1:0]     lw_addr_q;
  fsed_pkg::line_word_t          lw_data_q;

  logic                          wr_en;
  logic [fsed_pkg::ColW-1:0]     wr_addr;
  fsed_pkg::line_word_t          wr_data;

  // The below-left write replaces the held entry, which has the same column.
  always_comb begin
    wr_en       = ctrl_i.fire && (w1_en_i || tail_valid_q);
    wr_addr     = w1_en_i ? (s1_addr_i - 1'b1) : tail_addr_q;
    wr_data     = w1_en_i ? w1_data_i : tail_data_q;
    tail_valid_d = tail_valid_q;
    tail_addr_d  = tail_addr_q;
    tail_data_d  = tail_data_q;
    if (ctrl_i.fire) begin
      tail_valid_d = w2_en_i;
      tail_addr_d  = s1_addr_i;
      tail_data_d  = w2_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.accept) begin
      mem_rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_valid_q <= 1'b0;
      lw_valid_q   <= 1'b0;
    end else begin
      tail_valid_q <= tail_valid_d;
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tail_addr_q <= tail_addr_d;
    tail_data_q <= tail_data_d;
    if (wr_en) begin
      lw_addr_q <= wr_addr;
      lw_data_q <= wr_data;
    end
  end

  // Newest copy wins: held entry, then the last write, then the memory.
  always_comb begin
    if (tail_valid_q && (tail_addr_q == s1_addr_i)) begin
      rd_data_o = tail_data_q;
    end else if (lw_valid_q && (lw_addr_q == s1_addr_i)) begin
      rd_data_o = lw_data_q;
    end else begin
      rd_data_o = mem_rd_q;
    end
  end

endmodule

// ----- hdl/fsed_chan.sv -----
`timescale 1ns / 1ps

module fsed_chan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fsed_pkg::ctrl_t              ctrl_i,
  input  fsed_pkg::pos_t               pos_i,
  input  logic [fsed_pkg::ChanW-1:0]   pixel_i,
  input  fsed_pkg::err_t               line_err_i,
  output logic [fsed_pkg::ChanW-1:0]   level_o,
  output fsed_pkg::err_t               w1_err_o,
  output fsed_pkg::err_t               w2_err_o
);

  fsed_pkg::err_t                     rc_q, rc_d;
  fsed_pkg::err_t                     brc_q, brc_d;
  fsed_pkg::err_t                     bc_q, bc_d;

  fsed_pkg::err_t                     line_eff;
  logic [fsed_pkg::PxW-1:0]           px_fx;
  logic signed [fsed_pkg::SumW-1:0]   sum;
  logic [fsed_pkg::PxW-1:0]           clamped;
  logic [fsed_pkg::PxW-1:0]           rounded;
  logic [fsed_pkg::LevelBits-1:0]     k;
  fsed_pkg::err_t                     e;
  logic signed [fsed_pkg::MulW-1:0]   e7, e5, e3, e1;
  fsed_pkg::err_t                     f7, f5, f3, f1;

  // Line reads on the first row count as zero.
  assign line_eff = pos_i.row_nz ? line_err_i : '0;
  assign px_fx    = {pixel_i, {fsed_pkg::ErrFracBits{1'b0}}};

  // Add the carries, clamp, and round to the nearest level with ties up.
  always_comb begin
    sum = $signed({2'b00, px_fx}) + fsed_pkg::SumW'(rc_q) + fsed_pkg::SumW'(line_eff);
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed({2'b00, fsed_pkg::TopFx})) begin
      clamped = fsed_pkg::TopFx;
    end else begin
      clamped = sum[fsed_pkg::PxW-1:0];
    end
    rounded = clamped + fsed_pkg::HalfFx;
    k       = rounded[fsed_pkg::PxW-1:fsed_pkg::QuantShift];
    e       = fsed_pkg::ErrW'($signed({1'b0, clamped})
              - $signed({1'b0, k, {fsed_pkg::QuantShift{1'b0}}}));
  end

  assign level_o = {k, {(fsed_pkg::ChanW - fsed_pkg::LevelBits){1'b0}}};

  // Weighted shares in sixteenths, floored by the arithmetic shift.
  assign e7 = fsed_pkg::MulW'(e) * fsed_pkg::MulW'(7);
  assign e5 = fsed_pkg::MulW'(e) * fsed_pkg::MulW'(5);
  assign e3 = fsed_pkg::MulW'(e) * fsed_pkg::MulW'(3);
  assign e1 = fsed_pkg::MulW'(e);
  assign f7 = fsed_pkg::ErrW'(e7 >>> 4);
  assign f5 = fsed_pkg::ErrW'(e5 >>> 4);
  assign f3 = fsed_pkg::ErrW'(e3 >>> 4);
  assign f1 = fsed_pkg::ErrW'(e1 >>> 4);

  // Line store updates: below-left entry and the entry below.
  assign w1_err_o = bc_q + f3;
  assign w2_err_o = brc_q + f5;

  // Carry updates, cut at the last column and the last row.
  always_comb begin
    rc_d  = rc_q;
    brc_d = brc_q;
    bc_d  = bc_q;
    if (ctrl_i.fire) begin
      rc_d  = pos_i.last_col ? '0 : f7;
      brc_d = (pos_i.last_col || pos_i.last_row) ? '0 : f1;
      bc_d  = pos_i.last_row ? bc_q : w2_err_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      brc_q <= '0;
      bc_q  <= '0;
    end else begin
      rc_q  <= rc_d;
      brc_q <= brc_d;
      bc_q  <= bc_d;
    end
  end

endmodule

// ----- hdl/floyd_steinberg_error_diffusion.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Word
// in        input      in_valid_i / in_stall_o        fsed_pkg::pixel_t
// out       output     out_valid_o / out_stall_i      fsed_pkg::result_t
// cfg       input      cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One pixel per clock while out_stall_i is low: a word enters the working
// register, is quantized there against the line store read, and lands in
// the result register. out_valid_o rises as the word moves into the result
// register; a stall there holds the word in the working register.
// Reset clears the carries, raster counters and handshake state; the line
// store is not cleared, since first-row reads count as zero.
// A stalled result register holds the working register, which stalls input.

module floyd_steinberg_error_diffusion (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fsed_pkg::pixel_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fsed_pkg::result_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fsed_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fsed_pkg::CfgDataW-1:0]   cfg_data_i
);

  fsed_pkg::ctrl_t                 ctrl;
  fsed_pkg::pos_t                  pos;
  logic [fsed_pkg::ColW-1:0]       rd_addr;
  fsed_pkg::pixel_t                pixel_q;
  fsed_pkg::result_t               result_q, result_d;
  fsed_pkg::line_word_t            rd_data;
  fsed_pkg::line_word_t            w1_data;
  fsed_pkg::line_word_t            w2_data;
  logic                            w1_en;
  logic                            w2_en;

  fsed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_o      (ctrl),
    .pos_o       (pos),
    .rd_addr_o   (rd_addr)
  );

  // Working register for the accepted pixel.
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      pixel_q <= in_data_i;
    end
  end

  // Line store writes stop on the last row; below-left needs a left neighbor.
  assign w1_en = (pos.col != '0) && !pos.last_row;
  assign w2_en = !pos.last_row;

  fsed_line_store u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .rd_addr_i (rd_addr),
    .s1_addr_i (pos.col),
    .w1_en_i   (w1_en),
    .w1_data_i (w1_data),
    .w2_en_i   (w2_en),
    .w2_data_i (w2_data),
    .rd_data_o (rd_data)
  );

  fsed_chan u_blue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .pos_i      (pos),
    .pixel_i    (pixel_q.blue_in),
    .line_err_i (rd_data.blue),
    .level_o    (result_d.blue_level),
    .w1_err_o   (w1_data.blue),
    .w2_err_o   (w2_data.blue)
  );

  fsed_chan u_green (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .pos_i      (pos),
    .pixel_i    (pixel_q.green_in),
    .line_err_i (rd_data.green),
    .level_o    (result_d.green_level),
    .w1_err_o   (w1_data.green),
    .w2_err_o   (w2_data.green)
  );

  fsed_chan u_red (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .pos_i      (pos),
    .pixel_i    (pixel_q.red_in),
    .line_err_i (rd_data.red),
    .level_o    (result_d.red_level),
    .w1_err_o   (w1_data.red),
    .w2_err_o   (w2_data.red)
  );

  assign result_d.frame_end = pos.last_col && pos.last_row;

  // Result register, loaded as the working register moves on.
  always_ff @(posedge clk_i) begin
    if (ctrl.fire) begin
      result_q <= result_d;
    end
  end

  assign out_data_o = result_q;

endmodule
